/* src/jhs_pkg.sv */
// Shared types and constants for the joint homing sequencer.
package jhs_pkg;

  // Homing starts on its own after reset when set
  localparam bit AUTO_HOME_ON_BOOT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [31:0] SEEK_TIMEOUT_RST = 32'd10000;
  localparam logic [31:0] SETTLE_TIME_RST  = 32'd200;
  localparam logic [31:0] SEEK_STEP_RST    = 32'hFFFF_FC18;  // -1000

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_SEEK   = 3'd2,
    PH_SETTLE = 3'd3,
    PH_ZERO   = 3'd4,
    PH_DONE   = 3'd5,
    PH_FAULT  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_INIT         = 3'd1,
    ACT_DISABLE      = 3'd2,
    ACT_ENABLE       = 3'd3,
    ACT_STOP_DISABLE = 3'd4,
    ACT_SEEK_MOVE    = 3'd5,
    ACT_ZERO_HOLD    = 3'd6,
    ACT_ZERO_FAILED  = 3'd7
  } action_t;

  // Drive state classes
  localparam logic [2:0] DRV_UNKNOWN  = 3'd1;
  localparam logic [2:0] DRV_READY    = 3'd2;
  localparam logic [2:0] DRV_POWER_ON = 3'd3;
  localparam logic [2:0] DRV_ENABLED  = 3'd4;
  localparam logic [2:0] DRV_ALARM    = 3'd5;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEEK_TIMEOUT = 2'd0,
    CFG_SETTLE_TIME  = 2'd1,
    CFG_SEEK_STEP    = 2'd2
  } cfg_idx_t;

  // One tick request
  typedef struct packed {
    logic [31:0] now_ms;
    logic        emergency;
    logic        home_request;
    logic        lower_stop;
    logic [2:0]  drive_class;
    logic        move_rejected;
    logic        zero_rejected;
    logic        clear_fault;
  } tick_t;

  // One result request
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] move_value;
    logic               owns_axis;
    logic [2:0]         phase;
    logic               homed;
    logic               faulted;
    logic               pending;
    logic               busy_res;
  } result_t;

  function automatic logic phase_busy(input phase_t p);
    phase_busy = (p == PH_WAIT) || (p == PH_SEEK) || (p == PH_SETTLE) || (p == PH_ZERO);
  endfunction

endpackage

/* src/jhs_if.sv */
// Valid/ready channel interfaces for tick and result requests.
interface jhs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        emergency;
  logic        home_request;
  logic        lower_stop;
  logic [2:0]  drive_class;
  logic        move_rejected;
  logic        zero_rejected;
  logic        clear_fault;

  modport source (
    output valid, now_ms, emergency, home_request, lower_stop, drive_class,
           move_rejected, zero_rejected, clear_fault,
    input  ready
  );
  modport sink (
    input  valid, now_ms, emergency, home_request, lower_stop, drive_class,
           move_rejected, zero_rejected, clear_fault,
    output ready
  );
endinterface

interface jhs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] move_value;
  logic               owns_axis;
  logic [2:0]         phase;
  logic               homed;
  logic               faulted;
  logic               pending;
  logic               busy_res;

  modport source (
    output valid, action, move_value, owns_axis, phase, homed, faulted, pending, busy_res,
    input  ready
  );
  modport sink (
    input  valid, action, move_value, owns_axis, phase, homed, faulted, pending, busy_res,
    output ready
  );
endinterface

/* src/joint_homing_sequencer_unit.sv */
// Lower-limit homing sequencer: tick register, phase logic, result register.
//
//  channel  | dir | handshake          | contents
//  in_ch    | in  | valid/ready        | one control tick
//  out_ch   | out | valid/ready        | action, move value, homing status
//  cfg_*    | in  | cfg_we, no wait    | seek timeout, settle time, seek step
//
// Ticks pass tick then result register; one tick per cycle unless out_ch stalls.
// The phase update and result are formed in one pass between the tick and
// result registers; the 32-bit timestamp subtract-and-compare sets the path.
// Synchronous active-low reset puts homing in idle with a request pending.
// A stalled result holds; the tick register then fills and in_ch.ready drops.
module joint_homing_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  jhs_in_if.sink      in_ch,
  jhs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);
  import jhs_pkg::*;

  // Configuration
  logic [31:0] seek_timeout_r;
  logic [31:0] settle_time_r;
  logic [31:0] seek_step_r;

  // Homing state
  phase_t      phase_r, phase_nxt;
  logic        need_r, need_nxt;
  logic        homed_r, homed_nxt;
  logic        fault_r, fault_nxt;
  logic [31:0] seek_start_r, seek_start_nxt;
  logic [31:0] settle_start_r, settle_start_nxt;

  // Pipeline
  logic    tick_valid_r;
  tick_t   tick_r;
  logic    out_valid_r;
  result_t out_r, out_nxt;
  logic    out_load, tick_adv;

  // Decode
  logic        owns, abort_c, seek_late, settle_ok;
  logic [31:0] seek_el, settle_el;
  action_t     action_c;
  logic [31:0] move_c;

  assign out_load = !out_valid_r || out_ch.ready;
  assign tick_adv = tick_valid_r && out_load;
  assign in_ch.ready = !tick_valid_r || out_load;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_timeout_r <= SEEK_TIMEOUT_RST;
      settle_time_r  <= SETTLE_TIME_RST;
      seek_step_r    <= SEEK_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SEEK_TIMEOUT: seek_timeout_r <= cfg_wdata;
        CFG_SETTLE_TIME:  settle_time_r  <= cfg_wdata;
        CFG_SEEK_STEP:    seek_step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      tick_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tick_r.now_ms        <= in_ch.now_ms;
      tick_r.emergency     <= in_ch.emergency;
      tick_r.home_request  <= in_ch.home_request;
      tick_r.lower_stop    <= in_ch.lower_stop;
      tick_r.drive_class   <= in_ch.drive_class;
      tick_r.move_rejected <= in_ch.move_rejected;
      tick_r.zero_rejected <= in_ch.zero_rejected;
      tick_r.clear_fault   <= in_ch.clear_fault;
    end
  end

  // Shared conditions
  assign owns      = !tick_r.clear_fault && (need_r || phase_r == PH_FAULT || phase_r > PH_FAULT);
  assign abort_c   = tick_r.emergency || !tick_r.home_request || !need_r;
  assign seek_el   = tick_r.now_ms - seek_start_r;
  assign settle_el = tick_r.now_ms - settle_start_r;
  assign seek_late = seek_el > seek_timeout_r;
  assign settle_ok = settle_el >= settle_time_r;

  // Next phase and flags
  always_comb begin
    phase_nxt        = phase_r;
    need_nxt         = need_r;
    homed_nxt        = homed_r;
    fault_nxt        = fault_r;
    seek_start_nxt   = seek_start_r;
    settle_start_nxt = settle_start_r;
    if (tick_r.clear_fault) begin
      if (phase_r == PH_FAULT) begin
        phase_nxt        = PH_IDLE;
        need_nxt         = 1'b1;
        homed_nxt        = 1'b0;
        fault_nxt        = 1'b0;
        seek_start_nxt   = '0;
        settle_start_nxt = '0;
      end
    end else if (owns) begin
      if (abort_c) begin
        if (phase_busy(phase_r)) begin
          phase_nxt        = PH_IDLE;
          homed_nxt        = 1'b0;
          fault_nxt        = 1'b0;
          seek_start_nxt   = '0;
          settle_start_nxt = '0;
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            homed_nxt        = 1'b0;
            fault_nxt        = 1'b0;
            seek_start_nxt   = tick_r.now_ms;
            settle_start_nxt = '0;
            phase_nxt        = PH_WAIT;
          end
          PH_WAIT: begin
            if (tick_r.drive_class == DRV_ENABLED) begin
              seek_start_nxt = tick_r.now_ms;
              phase_nxt      = PH_SEEK;
            end else if (tick_r.drive_class == DRV_ALARM) begin
              need_nxt  = 1'b0;
              homed_nxt = 1'b0;
              fault_nxt = 1'b1;
              phase_nxt = PH_FAULT;
            end
          end
          PH_SEEK: begin
            if (seek_late || (!tick_r.lower_stop && tick_r.move_rejected)) begin
              need_nxt  = 1'b0;
              homed_nxt = 1'b0;
              fault_nxt = 1'b1;
              phase_nxt = PH_FAULT;
            end else if (tick_r.lower_stop) begin
              settle_start_nxt = tick_r.now_ms;
              phase_nxt        = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            if (settle_ok) phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (tick_r.zero_rejected) begin
              need_nxt  = 1'b0;
              homed_nxt = 1'b0;
              fault_nxt = 1'b1;
              phase_nxt = PH_FAULT;
            end else begin
              need_nxt  = 1'b0;
              homed_nxt = 1'b1;
              fault_nxt = 1'b0;
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: homed_nxt = 1'b1;
          default: homed_nxt = 1'b0;
        endcase
      end
    end
  end

  // Action and move value
  always_comb begin
    action_c = ACT_NONE;
    move_c   = '0;
    if (owns) begin
      if (abort_c) begin
        if (phase_busy(phase_r)) action_c = ACT_STOP_DISABLE;
      end else begin
        case (phase_r)
          PH_WAIT: begin
            case (tick_r.drive_class)
              DRV_UNKNOWN:  action_c = ACT_INIT;
              DRV_READY:    action_c = ACT_DISABLE;
              DRV_POWER_ON: action_c = ACT_ENABLE;
              DRV_ALARM:    action_c = ACT_STOP_DISABLE;
              default:      action_c = ACT_NONE;
            endcase
          end
          PH_SEEK: begin
            if (seek_late || tick_r.lower_stop || tick_r.move_rejected) begin
              action_c = ACT_STOP_DISABLE;
            end else begin
              action_c = ACT_SEEK_MOVE;
              move_c   = seek_step_r;
            end
          end
          PH_ZERO: action_c = tick_r.zero_rejected ? ACT_ZERO_FAILED : ACT_ZERO_HOLD;
          default: action_c = ACT_NONE;
        endcase
      end
    end
  end

  // Result assembly
  always_comb begin
    out_nxt.action     = action_c;
    out_nxt.move_value = move_c;
    out_nxt.owns_axis  = owns;
    out_nxt.phase      = phase_nxt;
    out_nxt.homed      = homed_nxt;
    out_nxt.faulted    = fault_nxt;
    out_nxt.pending    = need_nxt;
    out_nxt.busy_res   = phase_busy(phase_nxt);
  end

  // State registers, updated as a tick moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= AUTO_HOME_ON_BOOT ? PH_IDLE : PH_DONE;
      need_r         <= AUTO_HOME_ON_BOOT;
      homed_r        <= !AUTO_HOME_ON_BOOT;
      fault_r        <= 1'b0;
      seek_start_r   <= '0;
      settle_start_r <= '0;
    end else if (tick_adv) begin
      phase_r        <= phase_nxt;
      need_r         <= need_nxt;
      homed_r        <= homed_nxt;
      fault_r        <= fault_nxt;
      seek_start_r   <= seek_start_nxt;
      settle_start_r <= settle_start_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= tick_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_adv) out_r <= out_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.action     = out_r.action;
  assign out_ch.move_value = out_r.move_value;
  assign out_ch.owns_axis  = out_r.owns_axis;
  assign out_ch.phase      = out_r.phase;
  assign out_ch.homed      = out_r.homed;
  assign out_ch.faulted    = out_r.faulted;
  assign out_ch.pending    = out_r.pending;
  assign out_ch.busy_res   = out_r.busy_res;

  // Checks
  a_homed_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.homed && out_r.faulted))
    else $error("homed and faulted both set");

  a_seek_move_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.action == ACT_SEEK_MOVE) |-> (out_r.phase == PH_SEEK))
    else $error("seek move outside seek phase");

  a_no_own_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.owns_axis) |-> (out_r.action == ACT_NONE))
    else $error("action issued without owning the axis");

  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_valid_r && !tick_adv) |=> (tick_valid_r && $stable(tick_r)))
    else $error("stalled tick lost");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_adv |=> $stable(phase_r) && $stable(need_r))
    else $error("homing state moved without a tick");

endmodule
